// File: design/aits_pkg.sv
// Shared types, token codes, character codes and keyword table for the
// indent-aware token scanner. No dependencies.
package aits_pkg;

    localparam int DEF_INDENT_DEPTH = 16;
    localparam int MAX_DEDENTS      = 16;

    // Token kinds.
    localparam logic [5:0] K_IDENT   = 6'd0;
    localparam logic [5:0] K_NUMBER  = 6'd1;
    localparam logic [5:0] K_KW_BASE = 6'd2;
    localparam logic [5:0] K_DOT     = 6'd13;
    localparam logic [5:0] K_SEMI    = 6'd14;
    localparam logic [5:0] K_COLON   = 6'd15;
    localparam logic [5:0] K_COMMA   = 6'd16;
    localparam logic [5:0] K_EQUAL   = 6'd17;
    localparam logic [5:0] K_PLUS    = 6'd19;
    localparam logic [5:0] K_MINUS   = 6'd20;
    localparam logic [5:0] K_STAR    = 6'd21;
    localparam logic [5:0] K_SLASH   = 6'd23;
    localparam logic [5:0] K_GREATER = 6'd24;
    localparam logic [5:0] K_LESSER  = 6'd26;
    localparam logic [5:0] K_LPAREN  = 6'd28;
    localparam logic [5:0] K_RPAREN  = 6'd29;
    localparam logic [5:0] K_EOF     = 6'd30;
    localparam logic [5:0] K_NEWLINE = 6'd31;
    localparam logic [5:0] K_INDENT  = 6'd32;
    localparam logic [5:0] K_DEDENT  = 6'd33;
    localparam logic [5:0] K_ERROR   = 6'd34;
    localparam logic [5:0] K_NONE    = 6'd63;

    // Character codes.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LESS   = 8'h3C;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_GREAT  = 8'h3E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    localparam logic [23:0] POS_MAX = 24'hFFFFFF;
    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    // Keyword text, first byte in the low bits, and keyword lengths.
    localparam int NUM_KW = 11;
    localparam logic [47:0] KW_TEXT [NUM_KW] = '{
        48'h0000_0064_6e61, 48'h0000_6573_6c65, 48'h0000_6669_6c65,
        48'h0000_0000_6669, 48'h0065_736c_6166, 48'h6c61_626f_6c67,
        48'h0000_0074_6f6e, 48'h0000_0000_726f, 48'h0074_6e69_7270,
        48'h0000_6575_7274, 48'h0065_6c69_6877
    };
    localparam logic [15:0] KW_LEN [NUM_KW] = '{
        16'd3, 16'd4, 16'd4, 16'd2, 16'd5, 16'd6, 16'd3, 16'd2, 16'd5, 16'd4, 16'd5
    };

    // Which token the output register loads.
    typedef enum logic [1:0] {
        SEL_INDENT = 2'd0,
        SEL_DEDENT = 2'd1,
        SEL_TOK_A  = 2'd2,
        SEL_TOK_B  = 2'd3
    } emit_sel_t;

    typedef struct packed {
        logic      latch;
        logic      eval;
        logic      search;
        logic      emit;
        emit_sel_t emit_sel;
    } aits_cmd_t;

    typedef struct packed {
        logic ws_skip;
        logic ind_up;
        logic need_search;
        logic a_now;
        logic b_now;
        logic a_v;
        logic b_v;
        logic hit;
        logic miss;
        logic dcnt_one;
        logic out_free;
    } aits_sts_t;

    // Identifier to keyword kind on an exact match.
    function automatic logic [5:0] keyword_kind(input logic [47:0] prefix,
                                                input logic [15:0] len);
        logic [5:0] res;
        res = K_IDENT;
        for (int k = NUM_KW - 1; k >= 0; k--) begin
            if (len == KW_LEN[k] && prefix == KW_TEXT[k]) begin
                res = K_KW_BASE + 6'(k);
            end
        end
        return res;
    endfunction

endpackage

// File: design/aits_ctrl.sv
// Sequencing state machine of the token scanner: accept, evaluate, stack
// search and token emission. Depends on aits_pkg.
module aits_ctrl
    import aits_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  aits_sts_t sts,
    output aits_cmd_t cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_EVAL   = 7'b0000010,
        ST_IND    = 7'b0000100,
        ST_SEARCH = 7'b0001000,
        ST_DEDENT = 7'b0010000,
        ST_TOK_A  = 7'b0100000,
        ST_TOK_B  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.emit_sel = SEL_TOK_B;
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                cmd.latch = s_valid;
                if (s_valid) state_next = ST_EVAL;
            end
            ST_EVAL: begin
                cmd.eval = 1'b1;
                if (sts.ws_skip) state_next = ST_IDLE;
                else if (sts.ind_up) state_next = ST_IND;
                else if (sts.need_search) state_next = ST_SEARCH;
                else if (sts.a_now) state_next = ST_TOK_A;
                else if (sts.b_now) state_next = ST_TOK_B;
                else state_next = ST_IDLE;
            end
            ST_IND: begin
                cmd.emit_sel = SEL_INDENT;
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    state_next = sts.a_v ? ST_TOK_A : (sts.b_v ? ST_TOK_B : ST_IDLE);
                end
            end
            ST_SEARCH: begin
                cmd.search = 1'b1;
                if (sts.hit) state_next = ST_DEDENT;
                else if (sts.miss) begin
                    state_next = sts.a_v ? ST_TOK_A : (sts.b_v ? ST_TOK_B : ST_IDLE);
                end
            end
            ST_DEDENT: begin
                cmd.emit_sel = SEL_DEDENT;
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.dcnt_one) begin
                        state_next = sts.a_v ? ST_TOK_A : (sts.b_v ? ST_TOK_B : ST_IDLE);
                    end
                end
            end
            ST_TOK_A: begin
                cmd.emit_sel = SEL_TOK_A;
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    state_next = sts.b_v ? ST_TOK_B : ST_IDLE;
                end
            end
            ST_TOK_B: begin
                cmd.emit_sel = SEL_TOK_B;
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// File: design/aits_datapath.sv
// Datapath of the token scanner: scan state, pending token, indent stack
// memory and output register. Depends on aits_pkg.
module aits_datapath
    import aits_pkg::*;
#(
    parameter int INDENT_DEPTH = DEF_INDENT_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  s_char_code,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,
    input  aits_cmd_t   cmd,
    output aits_sts_t   sts,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_token_kind,
    output logic [23:0] m_token_start,
    output logic [15:0] m_token_length,
    output logic [23:0] m_line_number,
    output logic        m_last_of_run
);

    localparam int DW = $clog2(INDENT_DEPTH + 1);
    localparam int IW = $clog2(INDENT_DEPTH);

    logic [7:0]    char_reg;
    logic [3:0]    tab_reg;
    logic [7:0]    col_reg;
    logic          at_ls_reg;
    logic [DW-1:0] depth_reg;
    logic [7:0]    top_reg;
    logic [5:0]    pk_reg;
    logic [23:0]   pstart_reg;
    logic [15:0]   plen_reg;
    logic [47:0]   prefix_reg;
    logic [23:0]   pos_reg;
    logic [23:0]   line_reg;
    logic [23:0]   cur_pos_reg;
    logic [23:0]   cur_line_reg;
    logic          a_v_reg;
    logic [5:0]    a_kind_reg;
    logic [23:0]   a_start_reg;
    logic [15:0]   a_len_reg;
    logic          b_v_reg;
    logic [5:0]    b_kind_reg;
    logic [IW-1:0] idx_reg;
    logic [7:0]    rd_reg;
    logic [4:0]    dcnt_reg;
    logic          m_valid_reg;
    logic [5:0]    out_kind_reg;
    logic [23:0]   out_start_reg;
    logic [15:0]   out_len_reg;
    logic [23:0]   out_line_reg;
    logic          out_last_reg;
    logic [7:0]    levels_mem [INDENT_DEPTH];

    logic          digit, alpha, is_ws, ws_skip, check, ind_up, need_search;
    logic          ext, two, a_now, b_now;
    logic [5:0]    a_kind, b_kind;
    logic [15:0]   a_len;
    logic [7:0]    lvl;
    logic          hit, miss, out_free;
    logic [IW-1:0] rd_addr;
    logic [6:0]    pops;
    logic [8:0]    col_sum;
    logic [47:0]   prefix_ext;

    // Character classes and indentation decisions.
    always_comb begin
        digit   = char_reg >= 8'h30 && char_reg <= 8'h39;
        alpha   = (char_reg >= 8'h61 && char_reg <= 8'h7A) ||
                  (char_reg >= 8'h41 && char_reg <= 8'h5A);
        is_ws   = char_reg == CH_SPACE || char_reg == CH_TAB || char_reg == CH_CR;
        ws_skip = at_ls_reg && is_ws;
        check   = at_ls_reg && !is_ws;
        ind_up  = check && col_reg > top_reg && depth_reg < DW'(INDENT_DEPTH);
        need_search = check && col_reg < top_reg;
        col_sum = 9'(col_reg) + ((char_reg == CH_SPACE) ? 9'd1 : 9'(tab_reg));
    end

    // Pending token continuation, two-character operators and flush.
    always_comb begin
        ext = (pk_reg == K_IDENT && (alpha || digit || char_reg == CH_UNDER)) ||
              (pk_reg == K_NUMBER && (digit || char_reg == CH_DOT));
        two = (char_reg == CH_EQUAL &&
               (pk_reg == K_EQUAL || pk_reg == K_GREATER || pk_reg == K_LESSER)) ||
              (char_reg == CH_STAR && pk_reg == K_STAR);
        a_now  = !ws_skip && (two || (!ext && pk_reg != K_NONE));
        a_kind = two ? (pk_reg + 6'd1) :
                 ((pk_reg == K_IDENT) ? keyword_kind(prefix_reg, plen_reg) : pk_reg);
        a_len  = two ? 16'd2 : plen_reg;
        prefix_ext = prefix_reg;
        for (int i = 0; i < 6; i++) begin
            if (plen_reg == 16'(i)) prefix_ext[8*i +: 8] = char_reg;
        end
    end

    // Single-character tokens.
    always_comb begin
        b_now  = 1'b0;
        b_kind = K_ERROR;
        if (!ws_skip && !ext && !two && !digit && !alpha) begin
            b_now = 1'b1;
            unique case (char_reg)
                CH_SPACE, CH_TAB, CH_CR, CH_EQUAL, CH_STAR, CH_GREAT, CH_LESS:
                    b_now = 1'b0;
                CH_DOT:    b_kind = K_DOT;
                CH_SEMI:   b_kind = K_SEMI;
                CH_COLON:  b_kind = K_COLON;
                CH_COMMA:  b_kind = K_COMMA;
                CH_PLUS:   b_kind = K_PLUS;
                CH_MINUS:  b_kind = K_MINUS;
                CH_SLASH:  b_kind = K_SLASH;
                CH_LPAREN: b_kind = K_LPAREN;
                CH_RPAREN: b_kind = K_RPAREN;
                CH_NUL:    b_kind = K_EOF;
                CH_LF:     b_kind = K_NEWLINE;
                default:   b_kind = K_ERROR;
            endcase
        end
    end

    // Stack search compare; entry zero is always taken as level zero.
    always_comb begin
        lvl  = (idx_reg == '0) ? 8'd0 : rd_reg;
        hit  = lvl == col_reg;
        miss = !hit && (lvl < col_reg || idx_reg == '0);
        pops = 7'(depth_reg) - 7'(idx_reg) - 7'd1;
        rd_addr = cmd.eval ? IW'(depth_reg - DW'(2)) : (idx_reg - IW'(1));
        out_free = !m_valid_reg || m_ready;
    end

    // Indent stack memory with registered read.
    always_ff @(posedge aclk) begin
        rd_reg <= levels_mem[rd_addr];
        if (cmd.eval && ind_up) begin
            levels_mem[IW'(depth_reg)] <= col_reg;
        end
    end

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tab_reg <= 4'd4;
        end else if (cfg_wr_en) begin
            tab_reg <= cfg_wr_data;
        end
    end

    // Input byte capture.
    always_ff @(posedge aclk) begin
        if (cmd.latch) char_reg <= s_char_code;
    end

    // Scanner state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= 8'd0;
            at_ls_reg  <= 1'b1;
            depth_reg  <= DW'(1);
            top_reg    <= 8'd0;
            pk_reg     <= K_NONE;
            pstart_reg <= 24'd0;
            plen_reg   <= 16'd0;
            prefix_reg <= 48'd0;
            pos_reg    <= 24'd0;
            line_reg   <= 24'd1;
            a_v_reg    <= 1'b0;
            b_v_reg    <= 1'b0;
            dcnt_reg   <= 5'd0;
            idx_reg    <= '0;
        end else if (cmd.eval) begin
            cur_pos_reg  <= pos_reg;
            cur_line_reg <= line_reg;
            if (pos_reg != POS_MAX) pos_reg <= pos_reg + 24'd1;
            a_v_reg     <= a_now;
            a_kind_reg  <= a_kind;
            a_start_reg <= pstart_reg;
            a_len_reg   <= a_len;
            b_v_reg     <= b_now;
            b_kind_reg  <= b_kind;
            if (ws_skip) begin
                if (char_reg == CH_CR) col_reg <= 8'd0;
                else col_reg <= col_sum[8] ? 8'hFF : col_sum[7:0];
            end else begin
                at_ls_reg <= 1'b0;
                if (ind_up) begin
                    depth_reg <= depth_reg + DW'(1);
                    top_reg   <= col_reg;
                end
                if (need_search) idx_reg <= IW'(depth_reg - DW'(2));
                if (ext) begin
                    prefix_reg <= prefix_ext;
                    if (plen_reg != LEN_MAX) plen_reg <= plen_reg + 16'd1;
                end else begin
                    pk_reg     <= K_NONE;
                    plen_reg   <= 16'd0;
                    prefix_reg <= 48'd0;
                    if (!two) begin
                        if (digit || alpha || char_reg == CH_EQUAL || char_reg == CH_STAR ||
                            char_reg == CH_GREAT || char_reg == CH_LESS) begin
                            pk_reg     <= digit ? K_NUMBER : (alpha ? K_IDENT :
                                          (char_reg == CH_EQUAL ? K_EQUAL :
                                          (char_reg == CH_STAR ? K_STAR :
                                          (char_reg == CH_GREAT ? K_GREATER : K_LESSER))));
                            pstart_reg <= pos_reg;
                            plen_reg   <= 16'd1;
                            prefix_reg <= 48'(char_reg);
                        end
                        if (char_reg == CH_LF) begin
                            if (line_reg != POS_MAX) line_reg <= line_reg + 24'd1;
                            at_ls_reg <= 1'b1;
                            col_reg   <= 8'd0;
                        end
                    end
                end
            end
        end else if (cmd.search) begin
            if (hit) begin
                depth_reg <= DW'(idx_reg) + DW'(1);
                top_reg   <= col_reg;
                dcnt_reg  <= (pops > 7'(MAX_DEDENTS)) ? 5'(MAX_DEDENTS) : pops[4:0];
            end else if (!miss) begin
                idx_reg <= idx_reg - IW'(1);
            end
        end else if (cmd.emit && cmd.emit_sel == SEL_DEDENT) begin
            dcnt_reg <= dcnt_reg - 5'd1;
        end
    end

    // Output register; a token loads when the slot is free.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_line_reg <= cur_line_reg;
            unique case (cmd.emit_sel)
                SEL_INDENT: begin
                    out_kind_reg  <= K_INDENT;
                    out_start_reg <= cur_pos_reg;
                    out_len_reg   <= 16'd0;
                    out_last_reg  <= !a_v_reg && !b_v_reg;
                end
                SEL_DEDENT: begin
                    out_kind_reg  <= K_DEDENT;
                    out_start_reg <= cur_pos_reg;
                    out_len_reg   <= 16'd0;
                    out_last_reg  <= dcnt_reg == 5'd1 && !a_v_reg && !b_v_reg;
                end
                SEL_TOK_A: begin
                    out_kind_reg  <= a_kind_reg;
                    out_start_reg <= a_start_reg;
                    out_len_reg   <= a_len_reg;
                    out_last_reg  <= !b_v_reg;
                end
                SEL_TOK_B: begin
                    out_kind_reg  <= b_kind_reg;
                    out_start_reg <= cur_pos_reg;
                    out_len_reg   <= 16'd1;
                    out_last_reg  <= 1'b1;
                end
                default: out_last_reg <= 1'b1;
            endcase
        end
    end

    // Status to the controller and result ports.
    always_comb begin
        sts.ws_skip     = ws_skip;
        sts.ind_up      = ind_up;
        sts.need_search = need_search;
        sts.a_now       = a_now;
        sts.b_now       = b_now;
        sts.a_v         = a_v_reg;
        sts.b_v         = b_v_reg;
        sts.hit         = hit;
        sts.miss        = miss;
        sts.dcnt_one    = dcnt_reg == 5'd1;
        sts.out_free    = out_free;
    end

    assign m_valid        = m_valid_reg;
    assign m_token_kind   = out_kind_reg;
    assign m_token_start  = out_start_reg;
    assign m_token_length = out_len_reg;
    assign m_line_number  = out_line_reg;
    assign m_last_of_run  = out_last_reg;

endmodule

// File: design/indent_aware_token_scanner.sv
// Top level of the indent-aware token scanner: controller and datapath.
// Depends on aits_pkg, aits_ctrl and aits_datapath.
//
// Usage: one source byte per transaction on s_char_code (s_valid/s_ready);
// tokens leave on the m_ channel (m_valid/m_ready), one per transaction,
// with m_last_of_run set on the final token caused by a byte. A zero byte
// gives an end-of-text token. cfg_wr_en/cfg_wr_data set the tab width.
// Sequence: a byte is taken in the idle state and evaluated in the next
// cycle; each token it yields then has its own emission step into the output
// register. A dedent first runs a stack search that visits one level at a
// time (registered memory read), then emits its DEDENT tokens one by one.
// Reset (aresetn low, synchronous) empties the indent stack to level zero,
// drops any pending token, sets line 1, offset 0 and tab width 4; no
// clearing pass is needed.
// A stalled receiver holds the output register; the scanner waits in its
// emission step and takes no new byte until all tokens of the current byte
// are loaded into the output register.
module indent_aware_token_scanner
    import aits_pkg::*;
#(
    parameter int INDENT_DEPTH = DEF_INDENT_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_token_kind,
    output logic [23:0] m_token_start,
    output logic [15:0] m_token_length,
    output logic [23:0] m_line_number,
    output logic        m_last_of_run
);

    aits_cmd_t cmd;
    aits_sts_t sts;

    // Sequencer.
    aits_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Scanner state, indent stack and output register.
    aits_datapath #(
        .INDENT_DEPTH (INDENT_DEPTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_char_code    (s_char_code),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .cmd            (cmd),
        .sts            (sts),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_kind   (m_token_kind),
        .m_token_start  (m_token_start),
        .m_token_length (m_token_length),
        .m_line_number  (m_line_number),
        .m_last_of_run  (m_last_of_run)
    );

endmodule

// File: tb/indent_aware_token_scanner_tb.sv
// Self-checking testbench for the indent-aware token scanner.
// Depends on aits_pkg and the indent_aware_token_scanner RTL; a scoreboard class
// predicts the tokens of every accepted byte and checks each token that leaves.
module indent_aware_token_scanner_tb;
    import aits_pkg::*;

    typedef struct {
        logic [5:0]  kind;
        logic [23:0] start;
        logic [15:0] length;
        logic [23:0] line;
        logic        last;
    } token_t;

    // Token predictor with its own copy of the scanner state, plus the
    // queue of tokens that are still due.
    class token_scoreboard;
        token_t      due[$];
        logic [7:0]  levels[16];
        int          depth;
        bit          line_start;
        int          column;
        logic [5:0]  held_kind;
        int          held_start;
        int          held_len;
        logic [47:0] held_text;
        int          offset;
        int          line_no;
        logic [3:0]  tab_cols;
        int          errors;
        int          tokens_seen;
        int          made;
        string       words[11];

        function new();
            words = '{"and", "else", "elif", "if", "false", "global",
                      "not", "or", "print", "true", "while"};
            foreach (levels[i]) levels[i] = 8'd0;
            depth = 1;
            line_start = 1;
            column = 0;
            held_kind = K_NONE;
            held_start = 0;
            held_len = 0;
            held_text = '0;
            offset = 0;
            line_no = 1;
            tab_cols = 4'd4;
            errors = 0;
            tokens_seen = 0;
        endfunction

        function void add(logic [5:0] kind, int start, int len);
            token_t t;
            if (made >= 18) return;
            t.kind = kind;
            t.start = start[23:0];
            t.length = len[15:0];
            t.line = line_no[23:0];
            t.last = 1'b0;
            due.push_back(t);
            made++;
        endfunction

        // Identifiers become keywords only on an exact match of the text.
        function logic [5:0] word_kind();
            bit same;
            for (int k = 0; k < 11; k++) begin
                if (words[k].len() == held_len) begin
                    same = 1;
                    for (int i = 0; i < held_len; i++)
                        if (words[k][i] != held_text[8*i +: 8]) same = 0;
                    if (same) return K_KW_BASE + 6'(k);
                end
            end
            return K_IDENT;
        endfunction

        function void drop_held();
            held_kind = K_NONE;
            held_len = 0;
            held_text = '0;
        endfunction

        function void flush_held();
            logic [5:0] k;
            if (held_kind == K_NONE) return;
            k = (held_kind == K_IDENT) ? word_kind() : held_kind;
            add(k, held_start, held_len);
            drop_held();
        endfunction

        // Compare the indentation of a new line with the level stack.
        function void check_indent();
            int top;
            int pops;
            top = levels[depth - 1];
            if (column == top) return;
            if (column > top) begin
                if (depth < 16) begin
                    levels[depth] = column[7:0];
                    depth++;
                    add(K_INDENT, offset, 0);
                end
                return;
            end
            for (int m = 0; m + 1 < depth; m++) begin
                if (levels[m] == column) begin
                    pops = depth - 1 - m;
                    depth = m + 1;
                    if (pops > 16) pops = 16;
                    repeat (pops) add(K_DEDENT, offset, 0);
                    return;
                end
            end
        endfunction

        function void hold(logic [5:0] kind, logic [7:0] c);
            held_kind = kind;
            held_start = offset;
            held_len = 1;
            held_text = {40'd0, c};
        endfunction

        // Note one accepted byte and queue the tokens it causes.
        function void note_byte(logic [7:0] c);
            bit digit;
            bit alpha;
            bit finished;
            int queued_prior;
            digit = c >= "0" && c <= "9";
            alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
            made = 0;
            finished = 0;
            queued_prior = due.size();
            if (line_start) begin
                if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
                    if (c == CH_CR) column = 0;
                    else column += (c == CH_SPACE) ? 1 : int'(tab_cols);
                    if (column > 255) column = 255;
                    finished = 1;
                end else begin
                    line_start = 0;
                    check_indent();
                end
            end
            if (!finished && ((held_kind == K_IDENT && (alpha || digit || c == CH_UNDER)) ||
                              (held_kind == K_NUMBER && (digit || c == CH_DOT)))) begin
                if (held_len < 6) held_text[8*held_len +: 8] = c;
                if (held_len < 65535) held_len++;
                finished = 1;
            end
            if (!finished && ((c == CH_EQUAL && (held_kind == K_EQUAL ||
                    held_kind == K_GREATER || held_kind == K_LESSER)) ||
                    (c == CH_STAR && held_kind == K_STAR))) begin
                add(held_kind + 6'd1, held_start, 2);
                drop_held();
                finished = 1;
            end
            if (!finished) begin
                flush_held();
                if (digit) hold(K_NUMBER, c);
                else if (alpha) hold(K_IDENT, c);
                else begin
                    case (c)
                        CH_SPACE, CH_TAB, CH_CR: ;
                        CH_EQUAL: hold(K_EQUAL, c);
                        CH_STAR: hold(K_STAR, c);
                        CH_GREAT: hold(K_GREATER, c);
                        CH_LESS: hold(K_LESSER, c);
                        CH_DOT: add(K_DOT, offset, 1);
                        CH_SEMI: add(K_SEMI, offset, 1);
                        CH_COLON: add(K_COLON, offset, 1);
                        CH_COMMA: add(K_COMMA, offset, 1);
                        CH_PLUS: add(K_PLUS, offset, 1);
                        CH_MINUS: add(K_MINUS, offset, 1);
                        CH_SLASH: add(K_SLASH, offset, 1);
                        CH_LPAREN: add(K_LPAREN, offset, 1);
                        CH_RPAREN: add(K_RPAREN, offset, 1);
                        CH_NUL: add(K_EOF, offset, 1);
                        CH_LF: begin
                            add(K_NEWLINE, offset, 1);
                            if (line_no < 24'hFFFFFF) line_no++;
                            line_start = 1;
                            column = 0;
                        end
                        default: add(K_ERROR, offset, 1);
                    endcase
                end
            end
            if (offset < 24'hFFFFFF) offset++;
            if (due.size() > queued_prior) due[$].last = 1'b1;
        endfunction

        // Compare one handed-off token with the oldest one due.
        function void check_token(token_t got);
            token_t exp;
            tokens_seen++;
            if (due.size() == 0) begin
                $display("%0t: unexpected token kind %0d start %0d", $time, got.kind,
                         got.start);
                errors++;
                return;
            end
            exp = due.pop_front();
            if (got.kind !== exp.kind || got.start !== exp.start ||
                got.length !== exp.length || got.line !== exp.line ||
                got.last !== exp.last) begin
                $display("%0t: token mismatch expected %p actual %p", $time, exp, got);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_char_code;
    logic        cfg_wr_en;
    logic [3:0]  cfg_wr_data;
    logic        m_valid;
    logic        m_ready;
    logic [5:0]  m_token_kind;
    logic [23:0] m_token_start;
    logic [15:0] m_token_length;
    logic [23:0] m_line_number;
    logic        m_last_of_run;

    token_scoreboard tokens = new();
    bit  quiet;
    bit  long_hold;
    int  bytes_sent;
    int  settings_used;
    int  idle_cycles;

    indent_aware_token_scanner dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_char_code(s_char_code),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_token_kind(m_token_kind), .m_token_start(m_token_start),
        .m_token_length(m_token_length), .m_line_number(m_line_number),
        .m_last_of_run(m_last_of_run)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Monitor both channels and watch for a stalled run.
    always @(posedge aclk) begin
        token_t got;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (s_valid && s_ready) begin
                tokens.note_byte(s_char_code);
            end
            if (m_valid && m_ready) begin
                got.kind = m_token_kind;
                got.start = m_token_start;
                got.length = m_token_length;
                got.line = m_line_number;
                got.last = m_last_of_run;
                tokens.check_token(got);
            end
            if (idle_cycles >= 4000) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Receiver: random stall bursts, and one long hold-off on request.
    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (long_hold) begin
                long_hold = 0;
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
        end
    end

    // Offer one byte, possibly after a gap, and wait for its transaction.
    task automatic send_byte(input logic [7:0] c);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_char_code <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // Let the scanner drain, then write the tab width while it is idle.
    task automatic set_tab_width(input logic [3:0] w);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tokens.due.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= w;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tokens.tab_cols = w;
        settings_used++;
    endtask

    // One source line with random indentation and well-formed content.
    task automatic send_line();
        string pieces[18];
        pieces = '{"and ", "else", "elif ", "if ", "false", "global ", "not ", "or ",
                   "print", "true", "while ", "x_1", "3.14", "==", "**", ">=", "<= ",
                   "(a,b);"};
        if ($urandom_range(0, 7) == 0) send_byte(CH_CR);
        repeat ($urandom_range(0, 3)) send_byte($urandom_range(0, 1) ? CH_TAB : CH_SPACE);
        repeat ($urandom_range(1, 4)) begin
            send_text(pieces[$urandom_range(0, 17)]);
            if ($urandom_range(0, 3) == 0) send_byte($urandom_range(0, 1) ? CH_SPACE :
                                                     CH_DOT);
        end
        if ($urandom_range(0, 9) == 0) send_byte(CH_NUL);
        send_byte(CH_LF);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
    endtask

    // Staircase of lines, each indented deeper than the last by a mix of
    // tabs and spaces, past a full stack, then back to column zero for a
    // long run of dedents. The tab width must be at least four.
    task automatic send_staircase();
        for (int d = 1; d <= 16; d++) begin
            repeat (d / 4) send_byte(CH_TAB);
            repeat (d % 4) send_byte(CH_SPACE);
            send_text("v\n");
        end
        send_text("z\n");
    endtask

    task automatic random_phase(input int n);
        int stop_at;
        stop_at = bytes_sent + n;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(0, 9) < 8) send_line();
            else send_noise();
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_char_code = 8'd0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 4'd0;
        quiet = 0;
        long_hold = 0;
        bytes_sent = 0;
        settings_used = 1;
        idle_cycles = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: keywords, operators, numbers, lone dot, bad bytes,
        // indent, dedent to a matching level and a mismatched dedent.
        send_text("if x:\n\tprint 1.2.;\n  y<=a**b>=c\n\r.x_y\n  q\n ");
        send_byte(CH_NUL);
        send_byte(8'hFF);
        send_byte(CH_UNDER);
        send_text("\n= * > < ==\n");
        send_byte(8'h80);
        send_byte(8'h7F);
        send_text("-/+\n");

        // Random phases across several tab widths; the deep staircase runs
        // under a long receiver hold-off so the scanner backs up.
        set_tab_width(4'd1);
        random_phase(8);
        set_tab_width(4'd15);
        long_hold = 1;
        send_staircase();
        random_phase(8);
        set_tab_width(4'd8);
        random_phase(8);
        set_tab_width(4'd0);
        random_phase(8);
        set_tab_width(4'd3);
        quiet = 1;
        random_phase(8);
        s_valid <= 1'b0;

        // Drain and settle before the verdict.
        while (tokens.due.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        $display("Scanned %0d bytes into %0d checked tokens under %0d tab widths.",
                 bytes_sent, tokens.tokens_seen, settings_used);
        if (tokens.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
